/* rtl/sgpu_pkg.sv */
// Package for the scrolling strip chart pixel updater.
// Holds the register index codes and the command passed from front to back.
// No dependencies.
package sgpu_pkg;

    localparam int RegIdxW = 3;

    localparam logic [RegIdxW-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [RegIdxW-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [RegIdxW-1:0] REG_WIDTH    = 3'd2;
    localparam logic [RegIdxW-1:0] REG_HEIGHT   = 3'd3;
    localparam logic [RegIdxW-1:0] REG_X_GAIN   = 3'd4;
    localparam logic [RegIdxW-1:0] REG_Y_GAIN   = 3'd5;
    localparam logic [RegIdxW-1:0] REG_FG       = 3'd6;
    localparam logic [RegIdxW-1:0] REG_BG       = 3'd7;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_PLOT   = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] col;
        logic [7:0] height;
    } cmd_t;

    typedef struct packed {
        logic [7:0]  origin_x;
        logic [7:0]  bottom;
        logic [15:0] fg_colour;
        logic [15:0] bg_colour;
    } draw_cfg_t;

    typedef enum logic [1:0] {
        F_IDLE,
        F_MUL,
        F_DIV,
        F_PUSH
    } front_state_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_WALK,
        B_ERASE,
        B_PLOT,
        B_FLUSH
    } back_state_t;

endpackage

/* rtl/scrolling_graph_pixel_updater_top.sv */
// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | op, sample_y, sample_x
// out      | out_valid / out_stall| pixel_x, pixel_y, colour, last
// cfg      | cfg_we               | cfg_index, cfg_data
// An append item takes the front through one multiply and one division, a plot through
// two of each; the shared bit-serial remainder unit (33 steps per value) does each division.
// The back takes a command, walks the columns (every column for an append, only the
// addressed one for a plot), erases and replots each changed column, then flushes.
// Reset clears the column store and all control state at once; a stalled output
// holds its pixel while the front keeps quantizing the next item into the queue.
module scrolling_graph_pixel_updater_top
    import sgpu_pkg::*;
#(
    parameter int NUM_COLUMNS = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_stall,
    input  logic         op,
    input  logic [15:0]  sample_y,
    input  logic [15:0]  sample_x,
    output logic         out_valid,
    input  logic         out_stall,
    output logic [7:0]   pixel_x,
    output logic [7:0]   pixel_y,
    output logic [15:0]  colour,
    output logic         last,
    input  logic         cfg_we,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    localparam int WW = $clog2(NUM_COLUMNS + 1);

    logic [7:0]  origin_x_reg;
    logic [7:0]  origin_y_reg;
    logic [5:0]  width_reg;
    logic [7:0]  height_reg;
    logic [31:0] x_gain_reg;
    logic [31:0] y_gain_reg;
    logic [15:0] fg_reg;
    logic [15:0] bg_reg;

    logic [WW-1:0] w_eff;
    logic [7:0]    h_eff;
    draw_cfg_t     dcfg;
    logic          push;
    cmd_t          push_cmd;
    logic          q_full;
    logic          q_empty;
    logic          pop;
    cmd_t          pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= 8'd0;
            origin_y_reg <= 8'd0;
            width_reg    <= 6'd32;
            height_reg   <= 8'd64;
            x_gain_reg   <= 32'd65536;
            y_gain_reg   <= 32'd65536;
            fg_reg       <= 16'd65503;
            bg_reg       <= 16'd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_ORIGIN_X: origin_x_reg <= cfg_data[7:0];
                REG_ORIGIN_Y: origin_y_reg <= cfg_data[7:0];
                REG_WIDTH:    width_reg    <= cfg_data[5:0];
                REG_HEIGHT:   height_reg   <= cfg_data[7:0];
                REG_X_GAIN:   x_gain_reg   <= cfg_data;
                REG_Y_GAIN:   y_gain_reg   <= cfg_data;
                REG_FG:       fg_reg       <= cfg_data[15:0];
                REG_BG:       bg_reg       <= cfg_data[15:0];
                default:
                begin
                end
            endcase
        end
    end

    assign w_eff = (width_reg == 6'd0) ? WW'(1) :
                   (width_reg > 6'(NUM_COLUMNS)) ? WW'(NUM_COLUMNS) : WW'(width_reg);
    assign h_eff = (height_reg == 8'd0) ? 8'd1 : height_reg;

    assign dcfg.origin_x  = origin_x_reg;
    assign dcfg.bottom    = origin_y_reg + h_eff - 8'd1;
    assign dcfg.fg_colour = fg_reg;
    assign dcfg.bg_colour = bg_reg;

    sgpu_front #(
        .WW (WW)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .op       (op),
        .sample_y (sample_y),
        .sample_x (sample_x),
        .x_gain   (x_gain_reg),
        .y_gain   (y_gain_reg),
        .w_eff    (w_eff),
        .h_eff    (h_eff),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full)
    );

    sgpu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (pop),
        .empty    (q_empty),
        .pop_cmd  (pop_cmd)
    );

    sgpu_back #(
        .NUM_COLUMNS (NUM_COLUMNS),
        .WW          (WW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_empty   (q_empty),
        .pop       (pop),
        .cmd       (pop_cmd),
        .dcfg      (dcfg),
        .w_eff     (w_eff),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_x   (pixel_x),
        .pixel_y   (pixel_y),
        .colour    (colour),
        .last      (last)
    );

endmodule

/* rtl/sgpu_front.sv */
// Front part: accepts items and quantizes sample values into a height and, for a plot, a column.
// Uses sgpu_pkg; feeds commands into sgpu_queue.
module sgpu_front
    import sgpu_pkg::*;
#(
    parameter int WW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          op,
    input  logic [15:0]   sample_y,
    input  logic [15:0]   sample_x,
    input  logic [31:0]   x_gain,
    input  logic [31:0]   y_gain,
    input  logic [WW-1:0] w_eff,
    input  logic [7:0]    h_eff,
    output logic          push,
    output cmd_t          push_cmd,
    input  logic          q_full
);

    front_state_t state_reg, state_next;
    logic         op_reg;
    logic [15:0]  sy_reg;
    logic [15:0]  sx_reg;
    logic         phase_x_reg;
    logic [32:0]  dvd_reg;
    logic [7:0]   n_reg;
    logic [7:0]   rem_reg;
    logic [5:0]   cnt_reg;
    logic [7:0]   hq_reg;
    logic [7:0]   cq_reg;

    logic [15:0]  mul_a;
    logic [31:0]  mul_b;
    logic [47:0]  prod;
    logic [48:0]  rounded;
    logic [8:0]   trial;
    logic [7:0]   rem_next;
    logic         div_done;

    assign mul_a   = phase_x_reg ? sx_reg : sy_reg;
    assign mul_b   = phase_x_reg ? x_gain : y_gain;
    assign prod    = mul_a * mul_b;
    assign rounded = {1'b0, prod} + 49'h8000;
    assign trial   = {rem_reg, dvd_reg[32]};
    assign rem_next = (trial >= {1'b0, n_reg}) ? 8'(trial - {1'b0, n_reg}) : trial[7:0];
    assign div_done = (cnt_reg == 6'd1);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            F_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                state_next = F_DIV;
            end
            F_DIV:
            begin
                if (div_done)
                begin
                    if (!phase_x_reg && op_reg == OP_PLOT)
                    begin
                        state_next = F_MUL;
                    end
                    else
                    begin
                        state_next = F_PUSH;
                    end
                end
            end
            F_PUSH:
            begin
                if (!q_full)
                begin
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall = 1'b1;
        push     = 1'b0;
        unique case (state_reg)
            F_IDLE:  in_stall = 1'b0;
            F_PUSH:  push = !q_full;
            default: in_stall = 1'b1;
        endcase
    end

    assign push_cmd.op     = op_reg;
    assign push_cmd.col    = cq_reg;
    assign push_cmd.height = hq_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            F_IDLE:
            begin
                op_reg      <= op;
                sy_reg      <= sample_y;
                sx_reg      <= sample_x;
                phase_x_reg <= 1'b0;
                cq_reg      <= 8'd0;
            end
            F_MUL:
            begin
                dvd_reg <= rounded[48:16];
                n_reg   <= phase_x_reg ? 8'(w_eff) : h_eff;
                rem_reg <= 8'd0;
                cnt_reg <= 6'd33;
            end
            F_DIV:
            begin
                rem_reg <= rem_next;
                dvd_reg <= {dvd_reg[31:0], 1'b0};
                cnt_reg <= cnt_reg - 6'd1;
                if (div_done)
                begin
                    if (phase_x_reg)
                    begin
                        cq_reg <= rem_next;
                    end
                    else
                    begin
                        hq_reg      <= rem_next;
                        phase_x_reg <= 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

/* rtl/sgpu_queue.sv */
// Two-entry command queue between the front and back parts.
// Uses sgpu_pkg for the command type.
module sgpu_queue
    import sgpu_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic empty,
    output cmd_t pop_cmd
);

    cmd_t       mem_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign empty   = (count_reg == 2'd0);
    assign pop_cmd = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
        else $error("Queue written while full.");
    assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
        else $error("Queue read while empty.");
    assert property (@(posedge clk) disable iff (!rst_n) count_reg != 2'd3)
        else $error("Queue count exceeded its depth.");

endmodule

/* rtl/sgpu_back.sv */
// Back part: walks the column store, emits erase and plot pixel items.
// Uses sgpu_pkg; takes commands from sgpu_queue.
module sgpu_back
    import sgpu_pkg::*;
#(
    parameter int NUM_COLUMNS = 32,
    parameter int WW = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    output logic          pop,
    input  cmd_t          cmd,
    input  draw_cfg_t     dcfg,
    input  logic [WW-1:0] w_eff,
    output logic          out_valid,
    input  logic          out_stall,
    output logic [7:0]    pixel_x,
    output logic [7:0]    pixel_y,
    output logic [15:0]   colour,
    output logic          last
);

    localparam int CW = $clog2(NUM_COLUMNS);

    back_state_t state_reg, state_next;
    logic [7:0]    col_h_reg [NUM_COLUMNS];
    logic          op_reg;
    logic [CW-1:0] cur_col_reg;
    logic [7:0]    h_reg;

    logic          p_valid_reg;
    logic [7:0]    p_x_reg;
    logic [7:0]    p_y_reg;
    logic [15:0]   p_col_reg;

    logic          out_valid_reg;
    logic [7:0]    out_x_reg;
    logic [7:0]    out_y_reg;
    logic [15:0]   out_col_reg;
    logic          out_last_reg;

    logic [CW-1:0] last_col;
    logic          last_step;
    logic [7:0]    old_h;
    logic [7:0]    new_h;
    logic          out_free;
    logic          advance;
    logic          produce;
    logic          commit;
    logic [7:0]    prod_y;
    logic [15:0]   prod_col;

    assign last_col  = CW'(w_eff - WW'(1));
    assign last_step = (op_reg == OP_PLOT) || (cur_col_reg == last_col);
    assign old_h     = (op_reg == OP_PLOT) ? col_h_reg[cur_col_reg] : col_h_reg[0];
    assign new_h     = last_step ? h_reg : col_h_reg[1];
    assign out_free  = !out_valid_reg || !out_stall;
    assign advance   = !p_valid_reg || out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = B_WALK;
                end
            end
            B_WALK:
            begin
                if (old_h != new_h)
                begin
                    state_next = B_ERASE;
                end
                else if (last_step)
                begin
                    state_next = B_FLUSH;
                end
            end
            B_ERASE:
            begin
                if (advance)
                begin
                    state_next = B_PLOT;
                end
            end
            B_PLOT:
            begin
                if (advance)
                begin
                    state_next = last_step ? B_FLUSH : B_WALK;
                end
            end
            B_FLUSH:
            begin
                if (!p_valid_reg || out_free)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pop      = 1'b0;
        produce  = 1'b0;
        commit   = 1'b0;
        prod_y   = dcfg.bottom - old_h;
        prod_col = dcfg.bg_colour;
        unique case (state_reg)
            B_IDLE:
            begin
                pop = !q_empty;
            end
            B_WALK:
            begin
                commit = (old_h == new_h);
            end
            B_ERASE:
            begin
                produce = advance;
            end
            B_PLOT:
            begin
                produce  = advance;
                commit   = advance;
                prod_y   = dcfg.bottom - new_h;
                prod_col = dcfg.fg_colour;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_COLUMNS; k++)
            begin
                col_h_reg[k] <= 8'd0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (produce)
            begin
                p_valid_reg   <= 1'b1;
                out_valid_reg <= p_valid_reg ? 1'b1 : (out_valid_reg && out_stall);
            end
            else if (state_reg == B_FLUSH && p_valid_reg && out_free)
            begin
                p_valid_reg   <= 1'b0;
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (commit)
            begin
                if (op_reg == OP_PLOT)
                begin
                    col_h_reg[cur_col_reg] <= new_h;
                end
                else
                begin
                    for (int k = 0; k < NUM_COLUMNS; k++)
                    begin
                        if (CW'(k) == last_col)
                        begin
                            col_h_reg[k] <= new_h;
                        end
                        else if (CW'(k) < last_col && k < NUM_COLUMNS - 1)
                        begin
                            col_h_reg[k] <= col_h_reg[k + 1];
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == B_IDLE && !q_empty)
        begin
            op_reg      <= cmd.op;
            cur_col_reg <= (cmd.op == OP_PLOT) ? CW'(cmd.col) : '0;
            h_reg       <= cmd.height;
        end
        else if (commit && !last_step)
        begin
            cur_col_reg <= cur_col_reg + CW'(1);
        end
        if (produce)
        begin
            p_x_reg   <= dcfg.origin_x + 8'(cur_col_reg);
            p_y_reg   <= prod_y;
            p_col_reg <= prod_col;
        end
        if ((produce && p_valid_reg) || (state_reg == B_FLUSH && p_valid_reg && out_free))
        begin
            out_x_reg    <= p_x_reg;
            out_y_reg    <= p_y_reg;
            out_col_reg  <= p_col_reg;
            out_last_reg <= (state_reg == B_FLUSH);
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_x   = out_x_reg;
    assign pixel_y   = out_y_reg;
    assign colour    = out_col_reg;
    assign last      = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n) state_reg == B_IDLE |-> !p_valid_reg)
        else $error("Pending pixel left behind at the end of an item.");
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == B_WALK |-> cur_col_reg <= last_col)
        else $error("Column walk ran past the chart width.");
    assert property (@(posedge clk) disable iff (!rst_n) state_reg == B_ERASE |-> old_h != new_h)
        else $error("Erase started for an unchanged column.");

endmodule
